>>> hdl/ntpldst_pkg.sv
// shared types and constants for the ntp seconds to local time block
// reciprocal constants for the fixed divisions, calendar limits, csr indexes
// no dependencies
`timescale 1ns / 1ps

package ntpldst_pkg;

   // pipeline depth, input register to result register
   localparam int unsigned STAGES = 9;

   // configuration port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZONE_OFFSET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DAYLIGHT    = 2'd1;

   // time constants
   localparam logic [31:0] EPOCH_OFFSET = 32'd2208988800;
   localparam logic [31:0] SECS_HOUR    = 32'd3600;
   localparam logic [31:0] SECS_DAY     = 32'd86400;
   localparam logic [15:0] DAYS_WEEK    = 16'd7;
   localparam logic [15:0] THU_TO_SUN   = 16'd4;
   localparam logic [17:0] DAYS_YEAR    = 18'd365;

   // divide by constant via multiply and shift, exact over the value ranges used
   // days = (t >> 7) / 675
   localparam int unsigned DAY_SHIFT = 35;
   localparam logic [25:0] DAY_RECIP =
      26'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);
   // hour = (sod >> 4) / 225
   localparam int unsigned HOUR_SHIFT = 21;
   localparam logic [13:0] HOUR_RECIP =
      14'(((64'd1 << HOUR_SHIFT) + 64'd224) / 64'd225);
   // doe / 1460
   localparam int unsigned Q4Y_SHIFT = 28;
   localparam logic [17:0] Q4Y_RECIP =
      18'(((64'd1 << Q4Y_SHIFT) + 64'd1459) / 64'd1460);
   // (days + 4) / 7
   localparam int unsigned WEEK_SHIFT = 19;
   localparam logic [16:0] WEEK_RECIP =
      17'(((64'd1 << WEEK_SHIFT) + 64'd6) / 64'd7);
   // x / 365
   localparam int unsigned YEAR_SHIFT = 26;
   localparam logic [17:0] YEAR_RECIP =
      18'(((64'd1 << YEAR_SHIFT) + 64'd364) / 64'd365);

   // 400-year era starting on march 1st
   localparam logic [15:0] ERA_SPLIT  = 16'd11017;   // day of 2000-03-01
   localparam logic [17:0] ERA_BEFORE = 18'd135080;  // 1600-03-01 to 1970-01-01
   localparam logic [17:0] ERA_LAST   = 18'd146096;
   localparam logic [17:0] CENT_DAYS  = 18'd36524;

   // day of year counted from march 1st
   localparam logic [8:0] DOY_MAR_END   = 9'd30;
   localparam logic [8:0] DOY_OCT_FIRST = 9'd214;
   localparam logic [8:0] DOY_OCT_END   = 9'd244;
   localparam logic [8:0] DOY_OCT_BASE  = 9'd213;
   localparam logic [4:0] LAST_DAY_31   = 5'd31;

   typedef struct packed {
      logic signed [4:0] zone;
      logic              dst_en;
   } cfg_type;

   typedef struct packed {
      logic [31:0] local_sec;
      logic [15:0] days;
      logic [16:0] sod;
      logic [17:0] doe;
   } days_out_type;

   typedef struct packed {
      logic [31:0] local_sec;
      logic [4:0]  hour;
      logic [2:0]  dow;
      logic [8:0]  doy;
   } civil_out_type;

   typedef struct packed {
      logic [31:0] local_sec;
      logic        summer;
   } result_type;

endpackage

>>> hdl/ntpldst_csr.sv
// configuration registers: zone offset and daylight enable
// depends on ntpldst_pkg
`timescale 1ns / 1ps

module ntpldst_csr
   import ntpldst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   logic signed [4:0] zone_ff;
   logic              dst_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= '0;
         dst_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ZONE_OFFSET: zone_ff <= $signed(csr_data[4:0]);
            CSR_DAYLIGHT:    dst_ff  <= csr_data[0];
            default:         ;
         endcase
      end
   end

   assign cfg.zone   = zone_ff;
   assign cfg.dst_en = dst_ff;

endmodule

>>> hdl/ntpldst_days.sv
// stages 0 to 2: epoch and zone shift, split into day count and second of day
// depends on ntpldst_pkg
`timescale 1ns / 1ps

module ntpldst_days
   import ntpldst_pkg::*;
(
   input  logic         clock,
   input  logic [2:0]   en,
   input  cfg_type      cfg,
   input  logic [31:0]  ntp_seconds,
   output days_out_type d_out
);

   logic [31:0] tz_sec;
   logic [31:0] s0_local_ff, s0_local_in;

   logic [50:0] day_prod;
   logic [31:0] s1_local_ff;
   logic [15:0] s1_days_ff, s1_days_in;

   logic [31:0]  day_sec;
   days_out_type s2_ff, s2_in;

   // stage 0: local standard time, wraps mod 2^32
   always_comb begin
      tz_sec      = {{27{cfg.zone[4]}}, cfg.zone} * SECS_HOUR;
      s0_local_in = ntp_seconds - EPOCH_OFFSET + tz_sec;
   end

   always_ff @(posedge clock) begin
      if (en[0]) s0_local_ff <= s0_local_in;
   end

   // stage 1: day count, 86400 = 128 * 675
   always_comb begin
      day_prod   = 51'(s0_local_ff[31:7]) * 51'(DAY_RECIP);
      s1_days_in = day_prod[DAY_SHIFT +: 16];
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_local_ff <= s0_local_ff;
         s1_days_ff  <= s1_days_in;
      end
   end

   // stage 2: second of day and day of 400-year era
   always_comb begin
      day_sec         = 32'(s1_days_ff) * SECS_DAY;
      s2_in.local_sec = s1_local_ff;
      s2_in.days      = s1_days_ff;
      s2_in.sod       = 17'(s1_local_ff - day_sec);
      if (s1_days_ff < ERA_SPLIT) begin
         s2_in.doe = 18'(s1_days_ff) + ERA_BEFORE;
      end else begin
         s2_in.doe = 18'(s1_days_ff) - 18'(ERA_SPLIT);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) s2_ff <= s2_in;
   end

   assign d_out = s2_ff;

endmodule

>>> hdl/ntpldst_civil.sv
// stages 3 to 6: hour, weekday and day of year from the day count
// depends on ntpldst_pkg
`timescale 1ns / 1ps

module ntpldst_civil
   import ntpldst_pkg::*;
(
   input  logic          clock,
   input  logic [3:0]    en,
   input  days_out_type  d_in,
   output civil_out_type c_out
);

   // stage 3
   logic [26:0] hour_prod;
   logic [35:0] q4_prod;
   logic [32:0] wk_prod;
   logic [15:0] days4;
   logic [2:0]  cent_in;
   logic [31:0] s3_local_ff;
   logic [4:0]  s3_hour_ff;
   logic [17:0] s3_doe_ff;
   logic [6:0]  s3_q4_ff;
   logic [2:0]  s3_cent_ff;
   logic        s3_last_ff;
   logic [15:0] s3_days4_ff;
   logic [12:0] s3_wq_ff;

   // stage 4
   logic [31:0] s4_local_ff;
   logic [4:0]  s4_hour_ff;
   logic [17:0] s4_doe_ff;
   logic [17:0] s4_x_ff, s4_x_in;
   logic [2:0]  s4_dow_ff, s4_dow_in;

   // stage 5
   logic [35:0] yr_prod;
   logic [31:0] s5_local_ff;
   logic [4:0]  s5_hour_ff;
   logic [17:0] s5_doe_ff;
   logic [2:0]  s5_dow_ff;
   logic [8:0]  s5_yoe_ff;

   // stage 6
   logic [1:0]    cent_y;
   civil_out_type s6_ff, s6_in;

   always_comb begin
      hour_prod = 27'(d_in.sod[16:4]) * 27'(HOUR_RECIP);
      q4_prod   = 36'(d_in.doe) * 36'(Q4Y_RECIP);
      days4     = d_in.days + THU_TO_SUN;
      wk_prod   = 33'(days4) * 33'(WEEK_RECIP);
      cent_in   = 3'(d_in.doe >= CENT_DAYS) + 3'(d_in.doe >= 18'(2 * CENT_DAYS))
                + 3'(d_in.doe >= 18'(3 * CENT_DAYS)) + 3'(d_in.doe >= 18'(4 * CENT_DAYS));
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s3_local_ff <= d_in.local_sec;
         s3_hour_ff  <= hour_prod[HOUR_SHIFT +: 5];
         s3_doe_ff   <= d_in.doe;
         s3_q4_ff    <= q4_prod[Q4Y_SHIFT +: 7];
         s3_cent_ff  <= cent_in;
         s3_last_ff  <= (d_in.doe == ERA_LAST);
         s3_days4_ff <= days4;
         s3_wq_ff    <= wk_prod[WEEK_SHIFT +: 13];
      end
   end

   // stage 4: year-of-era numerator and weekday, sunday = 0
   always_comb begin
      s4_x_in   = s3_doe_ff - 18'(s3_q4_ff) + 18'(s3_cent_ff) - 18'(s3_last_ff);
      s4_dow_in = 3'(s3_days4_ff - 16'(s3_wq_ff) * DAYS_WEEK);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s4_local_ff <= s3_local_ff;
         s4_hour_ff  <= s3_hour_ff;
         s4_doe_ff   <= s3_doe_ff;
         s4_x_ff     <= s4_x_in;
         s4_dow_ff   <= s4_dow_in;
      end
   end

   // stage 5: year of era
   assign yr_prod = 36'(s4_x_ff) * 36'(YEAR_RECIP);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s5_local_ff <= s4_local_ff;
         s5_hour_ff  <= s4_hour_ff;
         s5_doe_ff   <= s4_doe_ff;
         s5_dow_ff   <= s4_dow_ff;
         s5_yoe_ff   <= yr_prod[YEAR_SHIFT +: 9];
      end
   end

   // stage 6: day of year from march 1st
   always_comb begin
      cent_y          = 2'(s5_yoe_ff >= 9'd100) + 2'(s5_yoe_ff >= 9'd200)
                      + 2'(s5_yoe_ff >= 9'd300);
      s6_in.local_sec = s5_local_ff;
      s6_in.hour      = s5_hour_ff;
      s6_in.dow       = s5_dow_ff;
      s6_in.doy       = 9'(s5_doe_ff - 18'(s5_yoe_ff) * DAYS_YEAR
                           - 18'(s5_yoe_ff[8:2]) + 18'(cent_y));
   end

   always_ff @(posedge clock) begin
      if (en[3]) s6_ff <= s6_in;
   end

   assign c_out = s6_ff;

endmodule

>>> hdl/ntpldst_rule.sv
// stages 7 and 8: summer-time rule and result register
// depends on ntpldst_pkg
`timescale 1ns / 1ps

module ntpldst_rule
   import ntpldst_pkg::*;
(
   input  logic          clock,
   input  logic [1:0]    en,
   input  cfg_type       cfg,
   input  civil_out_type c_in,
   output result_type    r_out
);

   logic       is_mar, is_oct, is_mid;
   logic [4:0] day;
   logic [5:0] back, wrap7;

   logic [31:0] s7_local_ff;
   logic [4:0]  s7_hour_ff;
   logic        s7_mar_ff, s7_oct_ff, s7_mid_ff;
   logic [4:0]  s7_day_ff;
   logic [4:0]  s7_lastsun_ff;

   logic signed [11:0] diff;
   logic               summer;
   result_type         s8_ff, s8_in;

   // stage 7: month class, day of month, last sunday of the month
   always_comb begin
      is_mar = (c_in.doy <= DOY_MAR_END);
      is_oct = (c_in.doy >= DOY_OCT_FIRST) && (c_in.doy <= DOY_OCT_END);
      is_mid = (c_in.doy > DOY_MAR_END) && (c_in.doy < DOY_OCT_FIRST);
      if (is_mar) begin
         day = 5'(c_in.doy + 9'd1);
      end else begin
         day = 5'(c_in.doy - DOY_OCT_BASE);
      end
      // weekday of the 31st, folded mod 7
      back = 6'(c_in.dow) + 6'(LAST_DAY_31) - 6'(day);
      if (back >= 6'd35)      wrap7 = back - 6'd35;
      else if (back >= 6'd28) wrap7 = back - 6'd28;
      else if (back >= 6'd21) wrap7 = back - 6'd21;
      else if (back >= 6'd14) wrap7 = back - 6'd14;
      else if (back >= 6'd7)  wrap7 = back - 6'd7;
      else                    wrap7 = back;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s7_local_ff   <= c_in.local_sec;
         s7_hour_ff    <= c_in.hour;
         s7_mar_ff     <= is_mar;
         s7_oct_ff     <= is_oct;
         s7_mid_ff     <= is_mid;
         s7_day_ff     <= day;
         s7_lastsun_ff <= LAST_DAY_31 - 5'(wrap7);
      end
   end

   // stage 8: local hours past the 01:00 utc switch, sign decides
   always_comb begin
      diff = $signed({7'b0, s7_hour_ff})
           + 12'sd24 * ($signed({7'b0, s7_day_ff}) - $signed({7'b0, s7_lastsun_ff}))
           - 12'sd1 - $signed({{7{cfg.zone[4]}}, cfg.zone});
      summer = cfg.dst_en & (s7_mid_ff | (s7_mar_ff & ~diff[11]) | (s7_oct_ff & diff[11]));
      s8_in.summer    = summer;
      s8_in.local_sec = s7_local_ff + (summer ? SECS_HOUR : 32'd0);
   end

   always_ff @(posedge clock) begin
      if (en[1]) s8_ff <= s8_in;
   end

   assign r_out = s8_ff;

endmodule

>>> hdl/ntp_seconds_to_local_time_dst.sv
// top level: ntp transmit seconds to local unix time with european summer time
// depends on ntpldst_pkg, ntpldst_csr, ntpldst_days, ntpldst_civil, ntpldst_rule
`timescale 1ns / 1ps

// Takes the 32-bit ntp transmit seconds on req_tdata and returns local time as
// seconds since 1970 on rsp_tdata, with rsp_tuser set when one summer-time hour
// was added. The 1900-to-1970 offset is removed and the signed zone offset in
// hours is added, both mod 2^32; the local standard time is broken into a
// gregorian date and, with daylight enabled, the eu rule (last sunday of march
// to last sunday of october, switch at 01:00 utc) is applied. The block is a
// 9-stage pipeline: one item is accepted every cycle while req_tready is high,
// and its result is presented on rsp_tvalid from the result register of the
// last stage. The depth is set by the chain of reciprocal multiplies for the
// day count, the four-year split and the year of era.
// Each stage holds its item until the next stage is free, so bubbles close up
// and items keep entering behind a waiting result until all nine stages are
// full; only then does req_tready drop.
// Configuration is written through csr_* (index 0 zone offset, 5-bit signed;
// index 1 daylight enable) and must only change while no item is in flight.
module ntp_seconds_to_local_time_dst
   import ntpldst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input item
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,   // [31:0] ntp_seconds
   // result item
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,   // [31:0] local_seconds
   output logic                   rsp_tuser,   // [0] summer_applied
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type       cfg;
   days_out_type  days_out;
   civil_out_type civil_out;
   result_type    result;

   logic [STAGES-1:0] vld_ff, vld_in;
   logic [STAGES-1:0] en;

   // a stage moves when it is empty or the stage after it moves
   always_comb begin
      en[STAGES-1] = ~vld_ff[STAGES-1] | rsp_tready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         en[i] = ~vld_ff[i] | en[i+1];
      end
   end

   // stage valid bits
   always_comb begin
      vld_in[0] = en[0] ? req_tvalid : vld_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         vld_in[i] = en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = vld_ff[STAGES-1];
   assign rsp_tdata  = result.local_sec;
   assign rsp_tuser  = result.summer;

   // zone offset and daylight enable
   ntpldst_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // stages 0-2: local seconds, day count, second of day
   ntpldst_days u_days (
      .clock       (clock),
      .en          (en[2:0]),
      .cfg         (cfg),
      .ntp_seconds (req_tdata),
      .d_out       (days_out)
   );

   // stages 3-6: hour, weekday, day of year
   ntpldst_civil u_civil (
      .clock (clock),
      .en    (en[6:3]),
      .d_in  (days_out),
      .c_out (civil_out)
   );

   // stages 7-8: summer rule and result register
   ntpldst_rule u_rule (
      .clock (clock),
      .en    (en[8:7]),
      .cfg   (cfg),
      .c_in  (civil_out),
      .r_out (result)
   );

endmodule

>>> test/tb_ntp_seconds_to_local_time_dst.sv
// testbench for ntp_seconds_to_local_time_dst: ntp seconds in, local unix time and summer flag out
// checks every result against a calendar-based prediction under random idling on both sides
// depends on ntpldst_pkg and the block under test
`timescale 1ns / 1ps

module tb_ntp_seconds_to_local_time_dst;
   import ntpldst_pkg::*;

   localparam int CYCLE_LIMIT  = 400_000;
   localparam int PHASES       = 13;
   localparam int PHASE_ITEMS  = 118;
   localparam int PRINT_LIMIT  = 40;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [31:0]            req_tdata = '0;   // [31:0] ntp_seconds
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [31:0]            rsp_tdata;        // [31:0] local_seconds
   logic                   rsp_tuser;        // [0] summer_applied
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_ZONE_OFFSET;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // configuration as the block should currently hold it
   logic signed [4:0]      zone_cfg = 5'sd0;
   logic                   dst_cfg = 1'b0;

   logic [31:0]            ntp_pending[$];      // items waiting to be sent
   result_type             local_time_due[$];   // predicted results, oldest first
   int                     errors = 0;
   int                     cycles = 0;
   int                     idle_odds = 6;       // 1-in-n chance to start a burst, 0 = never
   int                     send_gap = 0;
   int                     rsp_stall = 0;

   ntp_seconds_to_local_time_dst dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // calendar helpers
   // ---------------------------------------------------------------------

   function automatic bit leap_year(input int unsigned yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   function automatic int unsigned month_len(input int unsigned yr, input int unsigned mon);
      case (mon)
         2: begin
            return leap_year(yr) ? 29 : 28;
         end
         4, 6, 9, 11: begin
            return 30;
         end
         default: begin
            return 31;
         end
      endcase
   endfunction

   // days from 1970-01-01 to the given date
   function automatic int unsigned epoch_day(input int unsigned yr, input int unsigned mon,
                                             input int unsigned day);
      int unsigned n;
      n = day - 1;
      for (int unsigned y = 1970; y < yr; y++) n += leap_year(y) ? 366 : 365;
      for (int unsigned m = 1; m < mon; m++) n += month_len(yr, m);
      return n;
   endfunction

   // ntp seconds for a utc date and second of day, mod 2^32
   function automatic logic [31:0] ntp_at(input int unsigned yr, input int unsigned mon,
                                          input int unsigned day, input int unsigned sec);
      return 32'(epoch_day(yr, mon, day)) * SECS_DAY + 32'(sec) + EPOCH_OFFSET;
   endfunction

   // ntp seconds of 01:00 utc on the last sunday of march or october
   function automatic logic [31:0] ntp_at_switch(input int unsigned yr, input int unsigned mon);
      int unsigned last_sunday;
      last_sunday = 31 - (epoch_day(yr, mon, 31) + 4) % 7;
      return ntp_at(yr, mon, last_sunday, 3600);
   endfunction

   // ---------------------------------------------------------------------
   // prediction: local standard time, then the eu summer-time rule
   // ---------------------------------------------------------------------

   function automatic result_type local_time_of(input logic [31:0] ntp);
      result_type  res;
      int          tz;
      logic [31:0] stamp;
      int unsigned days, hr, dow, yr, rest, mon;
      int          day, last_sunday;
      bit          summer;
      tz = int'(zone_cfg);
      stamp = ntp - EPOCH_OFFSET + 32'(tz * 3600);
      summer = 1'b0;
      if (dst_cfg) begin
         days = stamp / SECS_DAY;
         hr = (stamp % SECS_DAY) / SECS_HOUR;
         dow = (days + 4) % 7;   // 1970-01-01 was a thursday, sunday is 0
         yr = 1970;
         rest = days;
         while (rest >= (leap_year(yr) ? 366 : 365)) begin
            rest -= leap_year(yr) ? 366 : 365;
            yr++;
         end
         mon = 1;
         while (mon < 12 && rest >= month_len(yr, mon)) begin
            rest -= month_len(yr, mon);
            mon++;
         end
         day = int'(rest) + 1;
         if (mon > 3 && mon < 10) begin
            summer = 1'b1;
         end else if (mon == 3 || mon == 10) begin
            // both months end on the 31st: walk back from it to the last sunday
            last_sunday = 31 - ((int'(dow) + 31 - day) % 7);
            if (mon == 3)
               summer = int'(hr) + 24 * day >= 1 + tz + 24 * last_sunday;
            else
               summer = int'(hr) + 24 * day < 1 + tz + 24 * last_sunday;
         end
      end
      res.local_sec = summer ? stamp + SECS_HOUR : stamp;
      res.summer = summer;
      return res;
   endfunction

   // random timestamp, mostly close to a summer-time switch
   function automatic logic [31:0] random_ntp();
      int unsigned pick, yr, mon;
      int          delta;
      pick = $urandom_range(0, 99);
      yr = $urandom_range(1970, 2105);
      mon = $urandom_range(0, 1) ? 3 : 10;
      if (pick < 55) begin
         case ($urandom_range(0, 9))
            0: delta = -1;
            1: delta = 0;
            2, 3, 4, 5, 6: delta = int'($urandom_range(0, 14400)) - 7200;
            default: delta = int'($urandom_range(0, 6 * 86400)) - 3 * 86400;
         endcase
         return ntp_at_switch(yr, mon) + 32'(delta);
      end else if (pick < 70) begin
         return ntp_at(yr, mon, $urandom_range(1, 31), $urandom_range(0, 86399));
      end
      return $urandom();
   endfunction

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (errors < PRINT_LIMIT)
         $display("mismatch %s: expected %08h got %08h at %0t", what, want, got, $realtime);
      errors++;
   endtask

   // ---------------------------------------------------------------------
   // configuration writes, only while nothing is in flight
   // ---------------------------------------------------------------------

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      // the block masks to the register width
      if (index == CSR_ZONE_OFFSET)
         zone_cfg = data[4:0];
      else if (index == CSR_DAYLIGHT)
         dst_cfg = data[0];
   endtask

   task automatic set_config(input logic signed [4:0] zone, input logic dst);
      logic [CSR_DATA_W-1:0] data;
      // unused upper bits carry noise
      data = CSR_DATA_W'($urandom);
      data[4:0] = zone;
      csr_write(CSR_ZONE_OFFSET, data);
      data = CSR_DATA_W'($urandom);
      data[0] = dst;
      csr_write(CSR_DAYLIGHT, data);
   endtask

   // wait until every queued item went in and came back, then the extra cycles asked for
   task automatic settle(input int extra);
      while (ntp_pending.size() != 0 || req_tvalid || local_time_due.size() != 0)
         @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // driver: feeds the request side from ntp_pending, predicting on accept
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready)
            local_time_due.push_back(local_time_of(req_tdata));
         // only move on once the current item is taken
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
               // start an idle burst, this cycle included; send_gap counts the rest
               send_gap <= $urandom_range(0, 8);
               req_tvalid <= 1'b0;
            end else if (ntp_pending.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= ntp_pending.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: stalls the result side and compares each result
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (local_time_due.size() == 0) begin
               report_mismatch("unexpected result", '0, rsp_tdata);
            end else begin
               want = local_time_due.pop_front();
               if (rsp_tdata !== want.local_sec)
                  report_mismatch("local_seconds", want.local_sec, rsp_tdata);
               if (rsp_tuser !== want.summer)
                  report_mismatch("summer_applied", 32'(want.summer), 32'(rsp_tuser));
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            rsp_stall <= $urandom_range(0, 8);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, local_time_due.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus: directed items, then random phases under changing settings
   // ---------------------------------------------------------------------

   initial begin
      logic signed [4:0] zone;
      logic              dst;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zone 0, daylight off, so midsummer gets no extra hour
      ntp_pending.push_back(ntp_at(2024, 7, 15, 43200));
      ntp_pending.push_back(32'h0000_0000);
      ntp_pending.push_back(32'hFFFF_FFFF);
      settle(STAGES + 2);

      // one hour east with summer time
      set_config(5'sd1, 1'b1);
      ntp_pending.push_back(32'h0000_0000);            // before 1970, wraps into 2036
      ntp_pending.push_back(32'hFFFF_FFFF);
      ntp_pending.push_back(EPOCH_OFFSET);              // 1970-01-01 utc
      ntp_pending.push_back(EPOCH_OFFSET - 32'd3601);   // local time lands on all ones
      ntp_pending.push_back(ntp_at_switch(2024, 3) - 32'd1);
      ntp_pending.push_back(ntp_at_switch(2024, 3));
      ntp_pending.push_back(ntp_at_switch(2024, 10) - 32'd1);
      ntp_pending.push_back(ntp_at_switch(2024, 10));
      // 2100 is not a leap year, weekdays must still line up
      ntp_pending.push_back(ntp_at_switch(2100, 3) - 32'd1);
      ntp_pending.push_back(ntp_at_switch(2100, 3));
      ntp_pending.push_back(ntp_at_switch(2100, 10) - 32'd1);
      ntp_pending.push_back(ntp_at_switch(2100, 10));
      ntp_pending.push_back(ntp_at_switch(1970, 3) - 32'd1);
      ntp_pending.push_back(ntp_at_switch(1970, 3));
      ntp_pending.push_back(ntp_at(2024, 2, 29, 82800));
      ntp_pending.push_back(ntp_at(2100, 3, 1, 0));
      ntp_pending.push_back(ntp_at(2024, 1, 15, 43200));
      ntp_pending.push_back(ntp_at(2024, 7, 15, 43200));
      settle(STAGES + 2);

      // west of utc: the switch falls on the saturday evening in local hours
      set_config(-5'sd5, 1'b1);
      ntp_pending.push_back(ntp_at_switch(2024, 3) - 32'd1);
      ntp_pending.push_back(ntp_at_switch(2024, 3));
      ntp_pending.push_back(ntp_at_switch(2024, 10) - 32'd1);
      ntp_pending.push_back(ntp_at_switch(2024, 10));
      settle(STAGES + 2);

      for (int p = 0; p < PHASES; p++) begin
         // extremes of the 5-bit zone first, then fixed and finally random settings
         case (p)
            0: begin zone = -5'sd16; dst = 1'b1; end
            1: begin zone = 5'sd15;  dst = 1'b1; end
            2: begin zone = 5'sd13;  dst = 1'b1; end
            3: begin zone = -5'sd11; dst = 1'b1; end
            4: begin zone = 5'sd0;   dst = 1'b1; end
            5: begin zone = 5'sd3;   dst = 1'b0; end
            6: begin zone = -5'sd1;  dst = 1'b1; end
            7: begin zone = -5'sd16; dst = 1'b0; end
            default: begin
               zone = 5'($urandom);
               dst = $urandom_range(0, 3) != 0;
            end
         endcase
         set_config(zone, dst);
         // idling varies by phase, none at all in the last one
         idle_odds = (p == PHASES - 1) ? 0 : $urandom_range(2, 12);
         for (int i = 0; i < PHASE_ITEMS; i++) ntp_pending.push_back(random_ntp());
         settle(STAGES + 2);
      end

      settle(STAGES * 4);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> filelist.f
hdl/ntpldst_pkg.sv
hdl/ntpldst_csr.sv
hdl/ntpldst_days.sv
hdl/ntpldst_civil.sv
hdl/ntpldst_rule.sv
hdl/ntp_seconds_to_local_time_dst.sv
test/tb_ntp_seconds_to_local_time_dst.sv
